// File: src/erq_pkg.sv
// shared types and constants for the event reorder queue
package erq_pkg;

   localparam int SecondsWidth = 32;
   localparam int NanosWidth   = 30;
   localparam int FidWidth     = 17;
   localparam int HandleWidth  = 32;
   localparam int OccWidth     = 7;

   localparam logic [1:0] STATUS_PUSHED  = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_POPPED  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic [HandleWidth-1:0]  handle;
      logic [SecondsWidth-1:0] seconds;
      logic [NanosWidth-1:0]   nanoseconds;
      logic [FidWidth-1:0]     fiducials;
      logic                    is_event;
   } entry_type;

   typedef struct packed {
      logic split_hit;
      logic walk_stop;
   } cmp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SPLIT_RD,
      S_SPLIT_EV,
      S_WALK_RD,
      S_WALK_EV,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_POP_RD,
      S_POP_HEAD,
      S_DOWN_RD,
      S_DOWN_WR,
      S_RESP
   } state_type;

endpackage

// File: src/erq_if.sv
// request and response channel interfaces
interface erq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic                               in_is_event;
   logic                               in_split;
   logic [erq_pkg::SecondsWidth-1:0]   in_seconds;
   logic [erq_pkg::NanosWidth-1:0]     in_nanoseconds;
   logic [erq_pkg::FidWidth-1:0]       in_fiducials;
   logic [erq_pkg::HandleWidth-1:0]    in_handle;

   modport source (output valid, req_type, in_is_event, in_split, in_seconds,
                   in_nanoseconds, in_fiducials, in_handle, input ready);
   modport sink (input valid, req_type, in_is_event, in_split, in_seconds,
                 in_nanoseconds, in_fiducials, in_handle, output ready);
endinterface

interface erq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [erq_pkg::HandleWidth-1:0]    out_handle;
   logic [erq_pkg::SecondsWidth-1:0]   out_seconds;
   logic [erq_pkg::NanosWidth-1:0]     out_nanoseconds;
   logic [erq_pkg::FidWidth-1:0]       out_fiducials;
   logic                               out_is_event;
   logic [erq_pkg::OccWidth-1:0]       occupancy;

   modport source (output valid, status, out_handle, out_seconds, out_nanoseconds,
                   out_fiducials, out_is_event, occupancy, input ready);
   modport sink (input valid, status, out_handle, out_seconds, out_nanoseconds,
                 out_fiducials, out_is_event, occupancy, output ready);
endinterface

// File: src/erq_mem.sv
// slot memory: one write port, one registered read port
module erq_mem #(
   parameter int Depth = 64,
   parameter int AddrWidth = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AddrWidth-1:0]      wr_addr,
   input  erq_pkg::entry_type        wr_data,
   input  logic [AddrWidth-1:0]      rd_addr,
   output erq_pkg::entry_type        rd_data
);
   erq_pkg::entry_type mem [Depth];
   erq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/erq_cmp.sv
// compare unit: split match and event walk stop against one queued slot
module erq_cmp (
   input  erq_pkg::entry_type slot,
   input  erq_pkg::entry_type hdr,
   output erq_pkg::cmp_type   result
);
   logic later;

   always_comb begin
      later = (hdr.seconds > slot.seconds) ||
              ((hdr.seconds == slot.seconds) && (hdr.nanoseconds > slot.nanoseconds));
      result.split_hit = (hdr.seconds == slot.seconds) && (hdr.fiducials == slot.fiducials);
      result.walk_stop = !slot.is_event || later;
   end
endmodule

// File: src/event_reorder_queue_core.sv
// event reorder queue: slot memory, compare unit and step sequencer
// one request at a time, stepped slot by slot through the single memory read port;
// the next request is taken while a response waits
// reset: synchronous, clears the entry count, the response valid and the sequencer;
// slot contents are not cleared
module event_reorder_queue_core #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   erq_req_if.sink       req_if,
   erq_rsp_if.source     rsp_if
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   erq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   erq_pkg::entry_type hdr_ff, hdr_in;
   erq_pkg::entry_type res_ff, res_in;
   logic [1:0]         stat_ff, stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   erq_pkg::entry_type rsp_ent_ff, rsp_ent_in;
   logic [1:0]         rsp_stat_ff, rsp_stat_in;
   logic [erq_pkg::OccWidth-1:0] rsp_occ_ff, rsp_occ_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   erq_pkg::entry_type wr_data, rd_data;
   erq_pkg::cmp_type   cmp;
   erq_pkg::entry_type req_ent;
   logic               accept;

   erq_mem #(.Depth(QUEUE_DEPTH), .AddrWidth(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   erq_cmp u_cmp (
      .slot   (rd_data),
      .hdr    (hdr_ff),
      .result (cmp)
   );

   assign req_if.ready = (state_ff == erq_pkg::S_IDLE);
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      req_ent.handle      = req_if.in_handle;
      req_ent.seconds     = req_if.in_seconds;
      req_ent.nanoseconds = req_if.in_nanoseconds;
      req_ent.fiducials   = req_if.in_fiducials;
      req_ent.is_event    = req_if.in_is_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= erq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      hdr_ff      <= hdr_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      rsp_ent_ff  <= rsp_ent_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      hdr_in       = hdr_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_ent_in   = rsp_ent_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_occ_in   = rsp_occ_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;
      rd_addr      = idx_ff[AW-1:0];

      unique case (state_ff)
         erq_pkg::S_IDLE: begin
            if (accept) begin
               hdr_in   = req_ent;
               res_in   = '0;
               if (req_if.req_type == erq_pkg::REQ_POP) begin
                  if (count_ff == '0) begin
                     stat_in  = erq_pkg::STATUS_EMPTY;
                     state_in = erq_pkg::S_RESP;
                  end else begin
                     idx_in   = '0;
                     state_in = erq_pkg::S_POP_RD;
                  end
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  stat_in  = erq_pkg::STATUS_FULL;
                  state_in = erq_pkg::S_RESP;
               end else if (req_if.in_split && count_ff != '0) begin
                  idx_in   = '0;
                  state_in = erq_pkg::S_SPLIT_RD;
               end else if (!req_if.in_is_event || count_ff == '0) begin
                  // append at tail; for an event into an empty queue tail is head
                  pos_in   = count_ff;
                  idx_in   = count_ff;
                  state_in = erq_pkg::S_SHIFT_RD;
               end else begin
                  idx_in   = count_ff - CW'(1);
                  state_in = erq_pkg::S_WALK_RD;
               end
            end
         end
         erq_pkg::S_SPLIT_RD: begin
            state_in = erq_pkg::S_SPLIT_EV;
         end
         erq_pkg::S_SPLIT_EV: begin
            if (cmp.split_hit) begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = erq_pkg::S_SHIFT_RD;
            end else if (idx_ff == count_ff - CW'(1)) begin
               // no matching piece, fall back to the ordinary rules
               if (!hdr_ff.is_event) begin
                  pos_in   = count_ff;
                  idx_in   = count_ff;
                  state_in = erq_pkg::S_SHIFT_RD;
               end else begin
                  idx_in   = count_ff - CW'(1);
                  state_in = erq_pkg::S_WALK_RD;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = erq_pkg::S_SPLIT_RD;
            end
         end
         erq_pkg::S_WALK_RD: begin
            state_in = erq_pkg::S_WALK_EV;
         end
         erq_pkg::S_WALK_EV: begin
            if (cmp.walk_stop) begin
               pos_in   = idx_ff + CW'(1);
               idx_in   = count_ff;
               state_in = erq_pkg::S_SHIFT_RD;
            end else if (idx_ff == '0) begin
               pos_in   = '0;
               idx_in   = count_ff;
               state_in = erq_pkg::S_SHIFT_RD;
            end else begin
               idx_in   = idx_ff - CW'(1);
               state_in = erq_pkg::S_WALK_RD;
            end
         end
         erq_pkg::S_SHIFT_RD: begin
            // idx is the slot being filled, moving toward the insert point
            if (idx_ff == pos_ff) begin
               state_in = erq_pkg::S_PLACE;
            end else begin
               rd_addr  = AW'(idx_ff - CW'(1));
               state_in = erq_pkg::S_SHIFT_WR;
            end
         end
         erq_pkg::S_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - CW'(1);
            state_in = erq_pkg::S_SHIFT_RD;
         end
         erq_pkg::S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            wr_data  = hdr_ff;
            count_in = count_ff + CW'(1);
            stat_in  = erq_pkg::STATUS_PUSHED;
            state_in = erq_pkg::S_RESP;
         end
         erq_pkg::S_POP_RD: begin
            state_in = erq_pkg::S_POP_HEAD;
         end
         erq_pkg::S_POP_HEAD: begin
            res_in   = rd_data;
            idx_in   = CW'(1);
            state_in = erq_pkg::S_DOWN_RD;
         end
         erq_pkg::S_DOWN_RD: begin
            if (idx_ff == count_ff) begin
               count_in = count_ff - CW'(1);
               stat_in  = erq_pkg::STATUS_POPPED;
               state_in = erq_pkg::S_RESP;
            end else begin
               state_in = erq_pkg::S_DOWN_WR;
            end
         end
         erq_pkg::S_DOWN_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff - CW'(1));
            idx_in   = idx_ff + CW'(1);
            state_in = erq_pkg::S_DOWN_RD;
         end
         erq_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ent_in   = res_ff;
               rsp_stat_in  = stat_ff;
               rsp_occ_in   = erq_pkg::OccWidth'(count_ff);
               state_in     = erq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = erq_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_stat_ff;
   assign rsp_if.out_handle      = rsp_ent_ff.handle;
   assign rsp_if.out_seconds     = rsp_ent_ff.seconds;
   assign rsp_if.out_nanoseconds = rsp_ent_ff.nanoseconds;
   assign rsp_if.out_fiducials   = rsp_ent_ff.fiducials;
   assign rsp_if.out_is_event    = rsp_ent_ff.is_event;
   assign rsp_if.occupancy       = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("ready again right after a beat");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != erq_pkg::S_PLACE && state_ff != erq_pkg::S_DOWN_RD) |=>
         $stable(count_ff))
      else $error("entry count changed outside place or pop");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == erq_pkg::STATUS_PUSHED) |->
         (rsp_if.occupancy != '0))
      else $error("push reported with empty queue");
endmodule
